/* rtl/core/srrw_pkg.sv */
// ----------------------------------------------------------------------------
// Selective-repeat receive window package
// Shared widths, limits and types for the receive window unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srrw_pkg;

  // Field widths of the segment header and result words.
  localparam int SEQ_W = 31;
  localparam int LEN_W = 16;
  localparam int TAG_W = 16;

  // Default window size in slots.
  localparam int WINDOW_SLOTS_DEF = 32;

  // At most this many segments are delivered for one arriving segment.
  localparam int MAX_DRAIN = 32;
  localparam int CNT_W     = $clog2(MAX_DRAIN + 1);

  // Result kinds.
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // Result control handed from the sequencer to the output stage.
  typedef struct packed {
    logic             strobe;
    logic             kind;
    logic [SEQ_W-1:0] ack_number;
    logic             transfer_done;
  } srrw_result_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/srrw_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srrw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/core/srrw_ctrl.sv */
// ----------------------------------------------------------------------------
// Receive window sequencer
// Checks each segment against the window and stores it if inside; a base hit
// walks the filled slots; each segment ends with a cumulative acknowledgement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srrw_ctrl
  import srrw_pkg::*;
#(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  output logic                           busy,
  input  wire [SEQ_W-1:0]                seq_number,
  input  wire                            end_of_transfer,
  input  wire [LEN_W-1:0]                payload_length,
  input  wire [TAG_W-1:0]                payload_tag,
  output logic                           mem_we,
  output logic [$clog2(WINDOW_SLOTS)-1:0] mem_waddr,
  output logic [LEN_W+TAG_W-1:0]         mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(WINDOW_SLOTS)-1:0] mem_raddr,
  output srrw_result_ctl_t               res_ctl
);

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_WRITE    = 5'b00010,
    ST_DRAIN_RD = 5'b00100,
    ST_DRAIN_WR = 5'b01000,
    ST_ACK      = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [SEQ_W-1:0]        base_r, base_nxt;
  logic [SLOT_W-1:0]       base_slot_r, base_slot_nxt;
  logic [SEQ_W-1:0]        final_seq_r, final_seq_nxt;
  logic                    final_seen_r, final_seen_nxt;
  logic [WINDOW_SLOTS-1:0] slot_full_r, slot_full_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  // Captured segment.
  logic [SEQ_W-1:0]  seq_r;
  logic              eot_r;
  logic [LEN_W-1:0]  len_r;
  logic [TAG_W-1:0]  tag_r;
  logic [SLOT_W-1:0] slot_r;
  logic              in_win_r;
  logic              is_base_r;

  logic              accept;
  logic [SEQ_W-1:0]  diff;
  logic              in_win;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] slot_idx;
  logic              drain_go;

  // A new segment may enter while idle or while the acknowledgement is out.
  assign busy   = !((state_r == ST_IDLE) || (state_r == ST_ACK));
  assign accept = start && !busy;

  // Window check and slot index, built from the tracked base slot.
  assign diff     = seq_number - base_r;
  assign in_win   = (seq_number >= base_r) && (diff < SEQ_W'(WINDOW_SLOTS));
  assign slot_sum = {1'b0, base_slot_r} + {1'b0, diff[SLOT_W-1:0]};
  assign slot_idx = (slot_sum >= (SLOT_W+1)'(WINDOW_SLOTS))
                    ? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_SLOTS))
                    : slot_sum[SLOT_W-1:0];

  assign drain_go = slot_full_r[base_slot_r] && (cnt_r < CNT_W'(MAX_DRAIN));

  // Capture the segment header at acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      seq_r     <= seq_number;
      eot_r     <= end_of_transfer;
      len_r     <= payload_length;
      tag_r     <= payload_tag;
      slot_r    <= slot_idx;
      in_win_r  <= in_win;
      is_base_r <= (seq_number == base_r);
    end
  end

  // Sequencer and window state.
  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    base_slot_nxt  = base_slot_r;
    final_seq_nxt  = final_seq_r;
    final_seen_nxt = final_seen_r;
    slot_full_nxt  = slot_full_r;
    cnt_nxt        = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cnt_nxt = '0;
        if (in_win_r) begin
          slot_full_nxt[slot_r] = 1'b1;
          if (eot_r) begin
            final_seq_nxt  = seq_r;
            final_seen_nxt = 1'b1;
          end
        end
        state_nxt = (in_win_r && is_base_r) ? ST_DRAIN_RD : ST_ACK;
      end
      ST_DRAIN_RD: begin
        state_nxt = drain_go ? ST_DRAIN_WR : ST_ACK;
      end
      ST_DRAIN_WR: begin
        // The read word is on the RAM output; retire the slot and move on.
        slot_full_nxt[base_slot_r] = 1'b0;
        base_nxt = base_r + 1'b1;
        if (base_r == {SEQ_W{1'b1}} || base_slot_r == SLOT_W'(WINDOW_SLOTS - 1)) begin
          base_slot_nxt = '0;
        end else begin
          base_slot_nxt = base_slot_r + 1'b1;
        end
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_DRAIN_RD;
      end
      ST_ACK: begin
        state_nxt = accept ? ST_WRITE : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      base_r       <= '0;
      base_slot_r  <= '0;
      final_seq_r  <= '0;
      final_seen_r <= 1'b0;
      slot_full_r  <= '0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      base_r       <= base_nxt;
      base_slot_r  <= base_slot_nxt;
      final_seq_r  <= final_seq_nxt;
      final_seen_r <= final_seen_nxt;
      slot_full_r  <= slot_full_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // Memory requests: store in the write state, fetch the base slot in a drain.
  assign mem_we    = (state_r == ST_WRITE) && in_win_r;
  assign mem_waddr = slot_r;
  assign mem_wdata = {len_r, tag_r};
  assign mem_re    = (state_r == ST_DRAIN_RD) && drain_go;
  assign mem_raddr = base_slot_r;

  // Result control toward the output stage.
  always_comb begin
    res_ctl               = '0;
    res_ctl.strobe        = (state_r == ST_DRAIN_WR) || (state_r == ST_ACK);
    res_ctl.kind          = (state_r == ST_ACK) ? KIND_ACK : KIND_DELIVER;
    if (state_r == ST_ACK) begin
      res_ctl.ack_number    = base_r;
      res_ctl.transfer_done = final_seen_r && (base_r > final_seq_r);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/selective_repeat_receive_window_unit.sv */
// ----------------------------------------------------------------------------
// Selective-repeat receive window unit
// Accepts one segment header per command, stores it in the slot memory when
// it lies in the window and delivers the in-order run followed by one
// cumulative acknowledgement. The header is stored in the write state, then
// each slot of the run is read and retired with one delivery; the read that
// ends the run is followed by the ack. A new segment may be accepted while
// the ack is out; busy holds it off during the write, read and retire steps.
// Reset (synchronous, active low) clears the base, the end mark and all slot
// occupied bits at once; the receiver takes every result without stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_receive_window_unit
  import srrw_pkg::*;
#(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  wire [SEQ_W-1:0]  in_seq_number,
  input  wire              in_end_of_transfer,
  input  wire [LEN_W-1:0]  in_payload_length,
  input  wire [TAG_W-1:0]  in_payload_tag,
  output logic             out_strobe,
  output logic             out_result_kind,
  output logic [TAG_W-1:0] out_delivered_tag,
  output logic [LEN_W-1:0] out_delivered_length,
  output logic [SEQ_W-1:0] out_ack_number,
  output logic             out_transfer_done,
  output logic             out_last_of_run
);

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int WORD_W = LEN_W + TAG_W;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  srrw_result_ctl_t  res_ctl;

  // Window sequencer.
  srrw_ctrl #(
    .WINDOW_SLOTS(WINDOW_SLOTS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .seq_number     (in_seq_number),
    .end_of_transfer(in_end_of_transfer),
    .payload_length (in_payload_length),
    .payload_tag    (in_payload_tag),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .res_ctl        (res_ctl)
  );

  // Slot memory holding length and tag of each stored segment.
  srrw_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WINDOW_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Result word: deliveries carry the memory word, the ack carries the base.
  always_comb begin
    out_strobe           = res_ctl.strobe;
    out_result_kind      = res_ctl.kind;
    out_ack_number       = res_ctl.ack_number;
    out_transfer_done    = res_ctl.transfer_done;
    out_last_of_run      = res_ctl.strobe && (res_ctl.kind == KIND_ACK);
    out_delivered_tag    = '0;
    out_delivered_length = '0;
    if (res_ctl.strobe && (res_ctl.kind == KIND_DELIVER)) begin
      out_delivered_tag    = mem_rdata[TAG_W-1:0];
      out_delivered_length = mem_rdata[WORD_W-1:TAG_W];
    end
  end

endmodule

`default_nettype wire

/* bench/tb_selective_repeat_receive_window_unit.sv */
// ----------------------------------------------------------------------------
// Selective-repeat receive window unit testbench
// Sends segment headers through the start/busy port and predicts every
// in-order delivery and acknowledgement that the window should produce.
// Each result word is checked field by field against the oldest expectation.
// The stimulus starts with a directed walk through the window's corner cases,
// then runs random fill rounds mixed with old, far and stray segments.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_selective_repeat_receive_window_unit;
  import srrw_pkg::*;

  localparam int WINDOW        = WINDOW_SLOTS_DEF;
  localparam int RANDOM_ITEMS  = 200;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PRINT_LIMIT   = 40;

  // One segment header as it is offered on the input port.
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             eot;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } segment_t;

  // One result word as it appears on the output port.
  typedef struct packed {
    logic             kind;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] ack;
    logic             done;
    logic             last;
  } result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [SEQ_W-1:0] in_seq_number = '0;
  logic             in_end_of_transfer = 1'b0;
  logic [LEN_W-1:0] in_payload_length = '0;
  logic [TAG_W-1:0] in_payload_tag = '0;
  logic             out_strobe;
  logic             out_result_kind;
  logic [TAG_W-1:0] out_delivered_tag;
  logic [LEN_W-1:0] out_delivered_length;
  logic [SEQ_W-1:0] out_ack_number;
  logic             out_transfer_done;
  logic             out_last_of_run;

  selective_repeat_receive_window_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_seq_number       (in_seq_number),
    .in_end_of_transfer  (in_end_of_transfer),
    .in_payload_length   (in_payload_length),
    .in_payload_tag      (in_payload_tag),
    .out_strobe          (out_strobe),
    .out_result_kind     (out_result_kind),
    .out_delivered_tag   (out_delivered_tag),
    .out_delivered_length(out_delivered_length),
    .out_ack_number      (out_ack_number),
    .out_transfer_done   (out_transfer_done),
    .out_last_of_run     (out_last_of_run)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_t pending_segments[$];
  result_t  expected_results[$];

  // Window state as the predictor sees it.
  logic [SEQ_W-1:0] win_base;
  logic [SEQ_W-1:0] end_seq;
  logic             end_seen;
  bit   [WINDOW-1:0] held;
  logic [LEN_W-1:0] held_len [WINDOW];
  logic [TAG_W-1:0] held_tag [WINDOW];

  // Light copy of the window used only to place generated segments.
  logic [SEQ_W-1:0] gen_base = '0;
  bit   [WINDOW-1:0] gen_full = '0;

  int unsigned random_items = 0;
  int unsigned n_errors = 0;
  int unsigned n_accepted = 0;
  int unsigned n_delivered = 0;
  int unsigned n_acks = 0;
  int unsigned n_done_acks = 0;
  int unsigned n_dropped = 0;
  int unsigned longest_drain = 0;
  int unsigned n_results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned gap_pct = 10;

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  function automatic bit in_window(input logic [SEQ_W-1:0] seq,
                                   input logic [SEQ_W-1:0] base);
    return seq >= base && ({1'b0, seq} - {1'b0, base}) < WINDOW;
  endfunction

  // Work out the result words caused by one accepted segment.
  task automatic predict_segment(input segment_t seg);
    int unsigned slot;
    int unsigned drained;
    result_t     r;
    drained = 0;
    if (in_window(seg.seq, win_base)) begin
      slot = seg.seq % WINDOW;
      held[slot]     = 1'b1;
      held_len[slot] = seg.len;
      held_tag[slot] = seg.tag;
      if (seg.eot) begin
        end_seq  = seg.seq;
        end_seen = 1'b1;
      end
      // The base segment releases the run of consecutive held slots.
      if (seg.seq == win_base) begin
        while (drained < MAX_DRAIN && held[win_base % WINDOW]) begin
          slot   = win_base % WINDOW;
          r      = '0;
          r.kind = KIND_DELIVER;
          r.tag  = held_tag[slot];
          r.len  = held_len[slot];
          expected_results.push_back(r);
          held[slot] = 1'b0;
          win_base   = win_base + 1'b1;
          drained++;
        end
      end
    end else begin
      n_dropped++;
    end
    n_delivered += drained;
    if (drained > longest_drain) longest_drain = drained;
    // Every segment ends with one cumulative acknowledgement.
    r      = '0;
    r.kind = KIND_ACK;
    r.ack  = win_base;
    r.done = end_seen && win_base > end_seq;
    r.last = 1'b1;
    expected_results.push_back(r);
    n_acks++;
    if (r.done) n_done_acks++;
  endtask

  // Queue one segment and advance the placement copy of the window.
  function automatic void queue_segment(input logic [SEQ_W-1:0] seq, input logic eot,
                                        input logic [LEN_W-1:0] len,
                                        input logic [TAG_W-1:0] tag);
    segment_t    seg;
    int unsigned n;
    seg.seq = seq;
    seg.eot = eot;
    seg.len = len;
    seg.tag = tag;
    pending_segments.push_back(seg);
    n = 0;
    if (in_window(seq, gen_base)) begin
      gen_full[seq % WINDOW] = 1'b1;
      if (seq == gen_base) begin
        while (n < MAX_DRAIN && gen_full[gen_base % WINDOW]) begin
          gen_full[gen_base % WINDOW] = 1'b0;
          gen_base = gen_base + 1'b1;
          n++;
        end
      end
    end
  endfunction

  // Payload fields lean toward their extremes now and then.
  function automatic logic [15:0] pick_field16();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic pick_eot();
    return $urandom_range(0, 11) == 0;
  endfunction

  // A stray segment: old, beyond the window, anywhere, a gap filler or the base.
  function automatic void queue_noise();
    logic [SEQ_W-1:0] seq;
    int unsigned      span;
    case ($urandom_range(0, 4))
      0: begin
        if (gen_base == 0) begin
          seq = gen_base + SEQ_W'(WINDOW);
        end else begin
          span = (gen_base > 40) ? 40 : gen_base - 1;
          seq  = gen_base - 1'b1 - SEQ_W'($urandom_range(0, span));
        end
      end
      1:       seq = gen_base + SEQ_W'(WINDOW) + SEQ_W'($urandom_range(0, 60));
      2:       seq = SEQ_W'($urandom());
      3:       seq = gen_base + SEQ_W'($urandom_range(1, WINDOW - 1));
      default: seq = gen_base;
    endcase
    queue_segment(seq, pick_eot(), pick_field16(), pick_field16());
    random_items++;
  endfunction

  // A well-formed round: every segment from the base up to base+k-1, shuffled,
  // with the base optionally held to the end and the odd stray segment mixed in.
  function automatic void queue_round(input int unsigned k, input bit base_last);
    logic [SEQ_W-1:0] order[$];
    logic [SEQ_W-1:0] b;
    logic [SEQ_W-1:0] tmp;
    int unsigned      i;
    int unsigned      j;
    int unsigned      top;
    b = gen_base;
    for (i = base_last ? 1 : 0; i < k; i++) order.push_back(b + SEQ_W'(i));
    top = order.size();
    for (i = top; i > 1; i--) begin
      j            = $urandom_range(0, i - 1);
      tmp          = order[i - 1];
      order[i - 1] = order[j];
      order[j]     = tmp;
    end
    if (base_last) order.push_back(b);
    for (i = 0; i < order.size(); i++) begin
      queue_segment(order[i], pick_eot(), pick_field16(), pick_field16());
      random_items++;
      if ($urandom_range(0, 9) == 0) queue_noise();
    end
  endfunction

  // Directed corner cases, then random rounds and noise.
  task automatic build_stimulus();
    // Out-of-order fill with field extremes and the window edges.
    queue_segment(31'd5, 1'b0, 16'h0000, 16'h0000);
    queue_segment(31'd3, 1'b0, 16'hFFFF, 16'hFFFF);
    queue_segment(31'd31, 1'b0, 16'h1234, 16'h4321);
    queue_segment(31'd32, 1'b0, 16'h0101, 16'h0202);
    queue_segment(31'h7FFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF);
    // Duplicate in the window overwrites its slot.
    queue_segment(31'd5, 1'b0, 16'h5555, 16'hAAAA);
    queue_segment(31'd1, 1'b0, 16'h0011, 16'h0110);
    queue_segment(31'd2, 1'b0, 16'h0022, 16'h0220);
    queue_segment(31'd4, 1'b0, 16'h0044, 16'h0440);
    // Base arrives and releases slots zero through five.
    queue_segment(31'd0, 1'b0, 16'h8000, 16'h0001);
    // Old segment with an end mark that must be ignored.
    queue_segment(31'd2, 1'b1, 16'h0033, 16'h0330);
    // Two end marks; the later one wins.
    queue_segment(31'd10, 1'b1, 16'h00A0, 16'h0A00);
    queue_segment(31'd8, 1'b1, 16'h0080, 16'h0800);
    queue_segment(31'd6, 1'b0, 16'h0060, 16'h0600);
    queue_segment(31'd7, 1'b0, 16'h0070, 16'h0700);
    // Transfer already done; the block keeps delivering.
    queue_segment(31'd9, 1'b0, 16'h0090, 16'h0900);
    // Long drain over the whole window, base last.
    queue_round(WINDOW, 1'b1);
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 65) begin
        queue_round(($urandom_range(0, 9) == 0) ? WINDOW : $urandom_range(1, 12),
                    $urandom_range(0, 3) == 0);
      end else begin
        queue_noise();
      end
    end
  endtask

  // Driver: offers the head of the pending queue, with random idle bursts.
  always @(posedge clk) begin : drive_proc
    logic take;
    take = start && !busy;
    if (!rst_n) begin
      win_base = '0;
      end_seq  = '0;
      end_seen = 1'b0;
      held     = '0;
      start <= 1'b0;
    end else begin
      if (take) begin
        predict_segment(pending_segments[0]);
        void'(pending_segments.pop_front());
        n_accepted++;
        if (n_accepted % 32 == 0) begin
          case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 8;
            default: gap_pct = 30;
          endcase
        end
      end
      // No idling in the last part of the run.
      if (pending_segments.size() < 40) gap_pct = 0;
      if (start && !take) begin
        // Word still waiting for acceptance: hold it.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_segments.size() != 0 && $urandom_range(0, 99) < gap_pct) begin
        gap_left = $urandom_range(0, 16);
        start <= 1'b0;
      end else if (pending_segments.size() != 0) begin
        start              <= 1'b1;
        in_seq_number      <= pending_segments[0].seq;
        in_end_of_transfer <= pending_segments[0].eot;
        in_payload_length  <= pending_segments[0].len;
        in_payload_tag     <= pending_segments[0].tag;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result word is matched against the oldest expectation.
  always @(posedge clk) begin : watch_proc
    result_t want;
    if (rst_n && out_strobe) begin
      n_results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected (kind %0b ack %0h)",
                                  n_results_seen, out_result_kind, out_ack_number));
      end else begin
        want = expected_results.pop_front();
        if (out_result_kind !== want.kind)
          report_mismatch($sformatf("result %0d result_kind got %0h expected %0h",
                                    n_results_seen, out_result_kind, want.kind));
        if (out_delivered_tag !== want.tag)
          report_mismatch($sformatf("result %0d delivered_tag got %0h expected %0h",
                                    n_results_seen, out_delivered_tag, want.tag));
        if (out_delivered_length !== want.len)
          report_mismatch($sformatf("result %0d delivered_length got %0h expected %0h",
                                    n_results_seen, out_delivered_length, want.len));
        if (out_ack_number !== want.ack)
          report_mismatch($sformatf("result %0d ack_number got %0h expected %0h",
                                    n_results_seen, out_ack_number, want.ack));
        if (out_transfer_done !== want.done)
          report_mismatch($sformatf("result %0d transfer_done got %0h expected %0h",
                                    n_results_seen, out_transfer_done, want.done));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("result %0d last_of_run got %0h expected %0h",
                                    n_results_seen, out_last_of_run, want.last));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still expected.",
               cycle_count, expected_results.size());
      $display("tb_selective_repeat_receive_window_unit: done, errors");
      $finish;
    end
  end

  // Reset, run all stimulus, drain and give the verdict.
  initial begin
    build_stimulus();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_segments.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d segment words: %0d in-order deliveries, %0d acks (%0d done).",
             n_accepted, n_delivered, n_acks, n_done_acks);
    $display("Dropped %0d old or far segments; longest drain %0d slots.",
             n_dropped, longest_drain);
    if (n_errors == 0) begin
      $display("tb_selective_repeat_receive_window_unit: done, clean");
    end else begin
      $display("tb_selective_repeat_receive_window_unit: done, errors");
    end
    $finish;
  end

endmodule
